@@ src/vlrb_pkg.sv @@
`timescale 1ns / 1ps
package vlrb_pkg;

   localparam int BUF_BYTES_DEF    = 1024;
   localparam int HEADER_BYTES_DEF = 6;
   localparam int FIELD_W          = 16;  // header fields are 16 bits
   localparam int IDX_W            = 16;  // widest byte index a command carries

   localparam logic [2:0] FUNC_PUSH     = 3'd0;
   localparam logic [2:0] FUNC_DEL_NEW  = 3'd1;
   localparam logic [2:0] FUNC_DEL_OLD  = 3'd2;
   localparam logic [2:0] FUNC_FLUSH    = 3'd3;
   localparam logic [2:0] FUNC_READ_NEW = 3'd4;
   localparam logic [2:0] FUNC_READ_OLD = 3'd5;

   typedef struct packed {
      logic [2:0] func;
      logic [9:0] item_len;
      logic [7:0] data_byte;
      logic [9:0] offset;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] read_byte;
      logic       push_done;
      logic [10:0] record_count;
      logic [9:0] head_size;
      logic [9:0] tail_size;
      logic       is_empty;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_RD,
      OP_HWR,
      OP_SET_EMPTY,
      OP_CLOSE,
      OP_DROP_OLD,
      OP_DROP_NEW,
      OP_PUSH_START,
      OP_PUSH_DATA,
      OP_SET_COMMIT,
      OP_SET_LINK,
      OP_COMMIT,
      OP_LOAD_HS,
      OP_LOAD_TS,
      OP_RESULT
   } dp_op_type;

   typedef enum logic [2:0] {
      RS_HEAD,
      RS_TAIL,
      RS_DATA_HEAD,
      RS_DATA_TAIL
   } rsel_type;

   typedef struct packed {
      dp_op_type        op;
      rsel_type         rsel;
      logic [IDX_W-1:0] idx;
      logic             take;
      logic             ok;
      logic             done;
      logic             rbyte_en;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic slot_found;
      logic len_bad;
      logic open;
      logic push_last;
      logic off_ok_head;
      logic off_ok_tail;
      logic rsp_busy;
   } status_type;

   // Byte k of a header image: next, prev, size (little endian), then zero pad.
   function automatic logic [7:0] hdr_byte(input logic [4:0] k,
                                           input logic [FIELD_W-1:0] nxt,
                                           input logic [FIELD_W-1:0] prv,
                                           input logic [FIELD_W-1:0] sz);
      logic [7:0] b;
      case (k)
         5'd0: b = nxt[7:0];
         5'd1: b = nxt[15:8];
         5'd2: b = prv[7:0];
         5'd3: b = prv[15:8];
         5'd4: b = sz[7:0];
         5'd5: b = sz[15:8];
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

@@ src/vlrb_ram.sv @@
`timescale 1ns / 1ps
module vlrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ src/vlrb_ctrl.sv @@
`timescale 1ns / 1ps
module vlrb_ctrl #(
   parameter int BUF_BYTES    = vlrb_pkg::BUF_BYTES_DEF,
   parameter int HEADER_BYTES = vlrb_pkg::HEADER_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_func,
   output logic                 req_ready,
   output vlrb_pkg::cmd_type    cmd,
   input  vlrb_pkg::status_type st
);
   import vlrb_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_FIND, S_RD_LO, S_RD_HI, S_RD_W,
      S_DROPO, S_DROPN, S_WR, S_DCHK, S_EMPTY, S_PDATA, S_SETC, S_LINK,
      S_COMMIT, S_REFR, S_LDH, S_LDT, S_RDW, S_RESULT
   } state_type;

   state_type        state_ff, state_in, ret_ff, ret_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [4:0]       hi_ff, hi_in;
   logic [2:0]       fidx_ff, fidx_in;
   rsel_type         rsel_ff, rsel_in;
   logic [2:0]       func_ff, func_in;
   logic             ok_ff, ok_in, done_ff, done_in, rb_ff, rb_in, push_ff, push_in;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      idx_in    = idx_ff;
      hi_in     = hi_ff;
      fidx_in   = fidx_ff;
      rsel_in   = rsel_ff;
      func_in   = func_ff;
      ok_in     = ok_ff;
      done_in   = done_ff;
      rb_in     = rb_ff;
      push_in   = push_ff;
      cmd       = '0;
      cmd.op    = OP_NONE;
      cmd.rsel  = RS_HEAD;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op  = OP_CLEAR;
            cmd.idx = idx_ff;
            if (idx_ff == IDX_W'(BUF_BYTES - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               func_in  = req_func;
               ok_in    = 1'b0;
               done_in  = 1'b0;
               rb_in    = 1'b0;
               push_in  = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESULT;
            case (func_ff)
               FUNC_PUSH: begin
                  if (st.open) begin
                     state_in = S_PDATA;
                  end else if (!st.len_bad) begin
                     push_in  = 1'b1;
                     state_in = S_FIND;
                  end
               end
               FUNC_DEL_NEW: begin
                  cmd.op = OP_CLOSE;
                  if (!st.count_zero) begin
                     ok_in    = 1'b1;
                     rsel_in  = RS_HEAD;
                     fidx_in  = 3'd2;
                     ret_in   = S_DROPN;
                     state_in = S_RD_LO;
                  end
               end
               FUNC_DEL_OLD: begin
                  cmd.op = OP_CLOSE;
                  if (!st.count_zero) begin
                     ok_in    = 1'b1;
                     rsel_in  = RS_TAIL;
                     fidx_in  = 3'd0;
                     ret_in   = S_DROPO;
                     state_in = S_RD_LO;
                  end
               end
               FUNC_FLUSH: begin
                  ok_in    = 1'b1;
                  ret_in   = S_REFR;
                  state_in = S_EMPTY;
               end
               FUNC_READ_NEW, FUNC_READ_OLD: begin
                  if (!st.count_zero &&
                      ((func_ff == FUNC_READ_NEW) ? st.off_ok_head : st.off_ok_tail)) begin
                     ok_in    = 1'b1;
                     rb_in    = 1'b1;
                     cmd.op   = OP_RD;
                     cmd.rsel = (func_ff == FUNC_READ_NEW) ? RS_DATA_HEAD : RS_DATA_TAIL;
                     state_in = S_RDW;
                  end
               end
               default: state_in = S_RESULT;
            endcase
         end
         S_FIND: begin
            if (st.slot_found) begin
               cmd.op   = OP_PUSH_START;
               state_in = S_PDATA;
            end else begin
               rsel_in  = RS_TAIL;
               fidx_in  = 3'd0;
               ret_in   = S_DROPO;
               state_in = S_RD_LO;
            end
         end
         S_RD_LO: begin
            cmd.op   = OP_RD;
            cmd.rsel = rsel_ff;
            cmd.idx  = IDX_W'(fidx_ff);
            state_in = S_RD_HI;
         end
         S_RD_HI: begin
            cmd.op   = OP_RD;
            cmd.rsel = rsel_ff;
            cmd.idx  = IDX_W'(fidx_ff) + IDX_W'(1);
            state_in = S_RD_W;
         end
         S_RD_W: state_in = ret_ff;
         S_DROPO: begin
            cmd.op   = OP_DROP_OLD;
            idx_in   = IDX_W'(2);
            hi_in    = 5'd3;
            ret_in   = S_DCHK;
            state_in = S_WR;
         end
         S_DROPN: begin
            cmd.op   = OP_DROP_NEW;
            idx_in   = '0;
            hi_in    = 5'd1;
            ret_in   = S_DCHK;
            state_in = S_WR;
         end
         S_WR: begin
            cmd.op  = OP_HWR;
            cmd.idx = idx_ff;
            if (idx_ff[4:0] == hi_ff) begin
               idx_in   = '0;
               state_in = ret_ff;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DCHK: begin
            if (st.count_zero) begin
               ret_in   = push_ff ? S_FIND : S_REFR;
               state_in = S_EMPTY;
            end else begin
               state_in = push_ff ? S_FIND : S_REFR;
            end
         end
         S_EMPTY: begin
            cmd.op   = OP_SET_EMPTY;
            idx_in   = '0;
            hi_in    = 5'(HEADER_BYTES - 1);
            state_in = S_WR;
         end
         S_PDATA: begin
            cmd.op   = OP_PUSH_DATA;
            ok_in    = 1'b1;
            state_in = st.push_last ? S_SETC : S_REFR;
         end
         S_SETC: begin
            cmd.op   = OP_SET_COMMIT;
            idx_in   = '0;
            hi_in    = 5'(HEADER_BYTES - 1);
            ret_in   = S_LINK;
            state_in = S_WR;
         end
         S_LINK: begin
            cmd.op   = OP_SET_LINK;
            idx_in   = '0;
            hi_in    = 5'd1;
            ret_in   = S_COMMIT;
            state_in = S_WR;
         end
         S_COMMIT: begin
            cmd.op   = OP_COMMIT;
            done_in  = 1'b1;
            state_in = S_REFR;
         end
         S_REFR: begin
            rsel_in  = RS_HEAD;
            fidx_in  = 3'd4;
            ret_in   = S_LDH;
            state_in = S_RD_LO;
         end
         S_LDH: begin
            cmd.op   = OP_LOAD_HS;
            rsel_in  = RS_TAIL;
            fidx_in  = 3'd4;
            ret_in   = S_LDT;
            state_in = S_RD_LO;
         end
         S_LDT: begin
            cmd.op   = OP_LOAD_TS;
            state_in = S_RESULT;
         end
         S_RDW: state_in = S_RESULT;
         S_RESULT: begin
            if (!st.rsp_busy) begin
               cmd.op       = OP_RESULT;
               cmd.ok       = ok_ff;
               cmd.done     = done_ff;
               cmd.rbyte_en = rb_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ret_ff   <= S_IDLE;
         idx_ff   <= '0;
         hi_ff    <= '0;
         fidx_ff  <= '0;
         rsel_ff  <= RS_HEAD;
         func_ff  <= '0;
         ok_ff    <= 1'b0;
         done_ff  <= 1'b0;
         rb_ff    <= 1'b0;
         push_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
         hi_ff    <= hi_in;
         fidx_ff  <= fidx_in;
         rsel_ff  <= rsel_in;
         func_ff  <= func_in;
         ok_ff    <= ok_in;
         done_ff  <= done_in;
         rb_ff    <= rb_in;
         push_ff  <= push_in;
      end
   end
endmodule

@@ src/vlrb_dpath.sv @@
`timescale 1ns / 1ps
module vlrb_dpath #(
   parameter int BUF_BYTES    = vlrb_pkg::BUF_BYTES_DEF,
   parameter int HEADER_BYTES = vlrb_pkg::HEADER_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vlrb_pkg::req_type    req_data,
   input  vlrb_pkg::cmd_type    cmd,
   output vlrb_pkg::status_type st,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output vlrb_pkg::rsp_type    rsp_data
);
   import vlrb_pkg::*;

   localparam int AW = $clog2(BUF_BYTES);
   localparam int CW = AW + 1;
   localparam int SW = FIELD_W + 2;

   function automatic logic [SW-1:0] wrap(input logic [SW-1:0] x);
      return (x >= SW'(BUF_BYTES)) ? x - SW'(BUF_BYTES) : x;
   endfunction

   req_type            req_ff;
   logic [AW-1:0]      head_ff, tail_ff, open_hdr_ff, base_ff;
   logic [CW-1:0]      count_ff;
   logic [FIELD_W-1:0] hsize_ff, tsize_ff, fnext_ff, fprev_ff, fsize_ff, tmp_ff;
   logic [9:0]         len_ff, seen_ff;
   logic               open_ff, rd_pend_ff, lane_ff, rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               we;
   logic [AW-1:0]      waddr, raddr;
   logic [7:0]         wdata, rdata;

   logic [SW-1:0]      e_pos, tl, lenx, top, bot;
   logic [AW-1:0]      slot;
   logic               found;
   logic [SW-1:0]      d_addr, r_rec, r_addr, h_waddr;

   // Header slot search against the newest record's end and the oldest start.
   always_comb begin
      e_pos = wrap(SW'(head_ff) + SW'(HEADER_BYTES) + SW'(hsize_ff));
      tl    = SW'(tail_ff);
      lenx  = SW'(req_ff.item_len);
      top   = '0;
      bot   = '0;
      slot  = '0;
      found = 1'b0;
      if (count_ff == '0) begin
         found = 1'b1;
      end else if (e_pos > tl) begin
         top = SW'(BUF_BYTES) - e_pos;
         bot = tl;
         if (top >= SW'(HEADER_BYTES)) begin
            slot  = AW'(e_pos);
            found = 1'b1;
            top   = top - SW'(HEADER_BYTES);
         end else begin
            top = '0;
            if (bot >= SW'(HEADER_BYTES)) begin
               found = 1'b1;
               bot   = bot - SW'(HEADER_BYTES);
            end
         end
         if (lenx > top + bot) begin
            found = 1'b0;
         end
      end else begin
         top = tl - e_pos;
         if (top >= SW'(HEADER_BYTES) + lenx) begin
            slot  = AW'(e_pos);
            found = 1'b1;
         end
         if (lenx > top) begin
            found = 1'b0;
         end
      end
   end

   always_comb begin
      d_addr  = wrap(wrap(SW'(open_hdr_ff) + SW'(HEADER_BYTES)) + SW'(seen_ff));
      h_waddr = wrap(SW'(base_ff) + SW'(cmd.idx[4:0]));
      r_rec   = '0;
      r_addr  = '0;
      case (cmd.rsel)
         RS_HEAD: r_addr = wrap(SW'(head_ff) + SW'(cmd.idx[4:0]));
         RS_TAIL: r_addr = wrap(SW'(tail_ff) + SW'(cmd.idx[4:0]));
         RS_DATA_HEAD, RS_DATA_TAIL: begin
            r_rec  = (cmd.rsel == RS_DATA_HEAD) ? SW'(head_ff) : SW'(tail_ff);
            r_addr = wrap(wrap(r_rec + SW'(HEADER_BYTES)) + SW'(req_ff.offset));
         end
         default: r_addr = '0;
      endcase
   end

   always_comb begin
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      case (cmd.op)
         OP_CLEAR: begin
            we    = 1'b1;
            waddr = cmd.idx[AW-1:0];
         end
         OP_HWR: begin
            we    = 1'b1;
            waddr = AW'(h_waddr);
            wdata = hdr_byte(cmd.idx[4:0], fnext_ff, fprev_ff, fsize_ff);
         end
         OP_PUSH_DATA: begin
            we    = 1'b1;
            waddr = AW'(d_addr);
            wdata = req_ff.data_byte;
         end
         default: we = 1'b0;
      endcase
   end

   assign raddr = AW'(r_addr);

   vlrb_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_pool (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      st             = '0;
      st.count_zero  = (count_ff == '0);
      st.slot_found  = found;
      st.len_bad     = (req_ff.item_len == 10'd0) ||
                       (SW'(req_ff.item_len) >= SW'(BUF_BYTES - HEADER_BYTES));
      st.open        = open_ff;
      st.push_last   = (11'(seen_ff) + 11'd1) >= 11'(len_ff);
      st.off_ok_head = FIELD_W'(req_ff.offset) < hsize_ff;
      st.off_ok_tail = FIELD_W'(req_ff.offset) < tsize_ff;
      st.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_ff <= req_data;
      end
      if (rd_pend_ff) begin
         if (lane_ff) begin
            tmp_ff[15:8] <= rdata;
         end else begin
            tmp_ff[7:0] <= rdata;
         end
      end
      lane_ff <= cmd.idx[0];
      case (cmd.op)
         OP_SET_EMPTY: begin
            base_ff  <= '0;
            fnext_ff <= '0;
            fprev_ff <= '0;
            fsize_ff <= '0;
         end
         OP_DROP_OLD: begin
            base_ff  <= tmp_ff[AW-1:0];
            fprev_ff <= tmp_ff;
         end
         OP_DROP_NEW: begin
            base_ff  <= tmp_ff[AW-1:0];
            fnext_ff <= tmp_ff;
         end
         OP_PUSH_START: begin
            open_hdr_ff <= slot;
            len_ff      <= req_ff.item_len;
         end
         OP_SET_COMMIT: begin
            base_ff  <= open_hdr_ff;
            fnext_ff <= FIELD_W'(open_hdr_ff);
            fprev_ff <= FIELD_W'(head_ff);
            fsize_ff <= FIELD_W'(len_ff);
         end
         OP_SET_LINK: begin
            base_ff  <= head_ff;
            fnext_ff <= FIELD_W'(open_hdr_ff);
         end
         OP_RESULT: begin
            rsp_ff.ok           <= cmd.ok;
            rsp_ff.read_byte    <= cmd.rbyte_en ? tmp_ff[7:0] : 8'd0;
            rsp_ff.push_done    <= cmd.done;
            rsp_ff.record_count <= 11'(count_ff);
            rsp_ff.head_size    <= (count_ff != '0) ? hsize_ff[9:0] : 10'd0;
            rsp_ff.tail_size    <= (count_ff != '0) ? tsize_ff[9:0] : 10'd0;
            rsp_ff.is_empty     <= (count_ff == '0);
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         hsize_ff     <= '0;
         tsize_ff     <= '0;
         seen_ff      <= '0;
         open_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= (cmd.op == OP_RD);
         if (cmd.op == OP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_SET_EMPTY: begin
               head_ff  <= '0;
               tail_ff  <= '0;
               count_ff <= '0;
               hsize_ff <= '0;
               tsize_ff <= '0;
               open_ff  <= 1'b0;
            end
            OP_CLOSE: open_ff <= 1'b0;
            OP_DROP_OLD: begin
               tail_ff  <= tmp_ff[AW-1:0];
               count_ff <= count_ff - 1'b1;
            end
            OP_DROP_NEW: begin
               head_ff  <= tmp_ff[AW-1:0];
               count_ff <= count_ff - 1'b1;
            end
            OP_PUSH_START: begin
               seen_ff <= '0;
               open_ff <= 1'b1;
            end
            OP_PUSH_DATA: seen_ff <= seen_ff + 1'b1;
            OP_COMMIT: begin
               head_ff  <= open_hdr_ff;
               count_ff <= count_ff + 1'b1;
               open_ff  <= 1'b0;
               seen_ff  <= '0;
            end
            OP_LOAD_HS: hsize_ff <= tmp_ff;
            OP_LOAD_TS: tsize_ff <= tmp_ff;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

@@ src/variable_length_overwrite_ring_buffer.sv @@
`timescale 1ns / 1ps
// Channel   Ports                              Carries
// request   req_valid, req_ready, req_data     command, push length, data byte, read offset
// response  rsp_valid, rsp_ready, rsp_data     status, read byte, count and record sizes
//
// One request at a time: the next request is taken only once the last response is
// loaded. Each push request carries one data byte; a record's first byte also searches
// for a header slot, dropping the oldest records to make room, and its last byte
// commits the record. A flush, or a delete or drop that empties the pool, rewrites the
// empty header. Every header field and data byte goes through the byte pool, which has
// one write port and one read port, one byte per cycle.
// After reset the pool is swept to zero, one byte a cycle, over all BUF_BYTES addresses;
// no request is taken during the sweep. A stalled response holds in the output register
// while the next request is already taken and worked on; its response then waits until
// the held one is accepted.
module variable_length_overwrite_ring_buffer #(
   parameter int BUF_BYTES    = vlrb_pkg::BUF_BYTES_DEF,
   parameter int HEADER_BYTES = vlrb_pkg::HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vlrb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vlrb_pkg::rsp_type rsp_data
);
   import vlrb_pkg::*;

   cmd_type    cmd;
   status_type st;

   // Sequence each request: slot search, oldest-record drops, header writes, refresh.
   vlrb_ctrl #(.BUF_BYTES(BUF_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .cmd       (cmd),
      .st        (st)
   );

   // Hold pointers, counts and cached sizes; own the pool and the response register.
   vlrb_dpath #(.BUF_BYTES(BUF_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
